>>> sv/ubsr_pkg.sv
// shared types, constants and state encoding for the unordered bag block
// no dependencies
package ubsr_pkg;

  // store geometry
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [1:0] CMD_ADD        = 2'd0;
  localparam logic [1:0] CMD_REMOVE_ONE = 2'd1;
  localparam logic [1:0] CMD_REMOVE_ALL = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] removed_count;
    logic [6:0] occupancy;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SWAP,
    S_REREAD,
    S_DONE
  } state_t;

endpackage

>>> sv/unordered_bag_swap_remove.sv
// Add, the unused code and a remove on an empty store go from the accepting edge straight to
// the result state. Remove compares one entry per cycle while it misses; a hit fetches the last
// entry and writes it into the hole, and the store shrinks. Remove-one then ends; remove-all
// rereads that slot and goes on comparing until it has passed the final slot.
// One transaction at a time: the next is taken the cycle after the result loads.
// Reset (rst, synchronous): clears count, sequencer and result valid; stored values are not.
module unordered_bag_swap_remove
  import ubsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;

  logic [1:0]             cmd_q;
  logic [VALUE_WIDTH-1:0] key, key_next;
  logic [ADDR_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       removed, removed_next;
  logic [1:0]             status, status_next;

  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                   req_fire, rsp_load, hit, more, keep_going;
  logic [CNT_W-1:0]       idx_ext, last_ext;

  ubsr_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake and compare helpers
  assign req_ready  = (state == S_IDLE);
  assign req_fire   = req_valid && req_ready;
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign hit        = (mem_rdata == key);
  assign idx_ext    = CNT_W'(idx);
  assign last_ext   = count - CNT_W'(1);
  assign more       = (idx_ext + CNT_W'(1)) < count;
  assign keep_going = (cmd_q == CMD_REMOVE_ALL) && (idx_ext < last_ext);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if ((req.cmd == CMD_REMOVE_ONE || req.cmd == CMD_REMOVE_ALL) &&
              count != '0) begin
            state_next = S_CMP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CMP: begin
        if (hit) begin
          state_next = S_SWAP;
        end else if (!more) begin
          state_next = S_DONE;
        end
      end
      S_SWAP: begin
        state_next = keep_going ? S_REREAD : S_DONE;
      end
      S_REREAD: begin
        state_next = S_CMP;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // memory controls and datapath next values
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = key;
    mem_re       = 1'b0;
    mem_raddr    = idx;
    key_next     = key;
    idx_next     = idx;
    count_next   = count;
    removed_next = removed;
    status_next  = status;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          key_next     = VALUE_WIDTH'(req.value);
          idx_next     = '0;
          removed_next = '0;
          status_next  = STAT_OK;
          case (req.cmd)
            CMD_ADD: begin
              if (count >= CNT_W'(CAPACITY)) begin
                status_next = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[ADDR_W-1:0];
                mem_wdata  = VALUE_WIDTH'(req.value);
                count_next = count + CNT_W'(1);
              end
            end
            CMD_REMOVE_ONE, CMD_REMOVE_ALL: begin
              if (count == '0) begin
                status_next = STAT_NOT_FOUND;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
              end
            end
            default: begin
              status_next = STAT_OK;
            end
          endcase
        end
      end
      S_CMP: begin
        if (hit) begin
          // fetch the last entry to move into the hole
          mem_re    = 1'b1;
          mem_raddr = last_ext[ADDR_W-1:0];
        end else if (more) begin
          mem_re    = 1'b1;
          mem_raddr = idx + ADDR_W'(1);
          idx_next  = idx + ADDR_W'(1);
        end else begin
          status_next = (removed == '0) ? STAT_NOT_FOUND : STAT_OK;
        end
      end
      S_SWAP: begin
        mem_we       = 1'b1;
        mem_waddr    = idx;
        mem_wdata    = mem_rdata;
        count_next   = last_ext;
        removed_next = removed + CNT_W'(1);
        status_next  = STAT_OK;
      end
      S_REREAD: begin
        mem_re    = 1'b1;
        mem_raddr = idx;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q <= req.cmd;
    end
    key     <= key_next;
    idx     <= idx_next;
    removed <= removed_next;
    status  <= status_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status        <= status;
      rsp.removed_count <= 7'(removed);
      rsp.occupancy     <= 7'(count);
    end
  end

endmodule

>>> sv/ubsr_ram.sv
// entry store: one write port, one read port with registered read data
// depends on ubsr_pkg for depth and width
module ubsr_ram
  import ubsr_pkg::*;
(
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ubsr_checker.sv
// port-level checks for the unordered bag block, attached by bind
// depends on ubsr_pkg for types and status codes
module ubsr_checker
  import ubsr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // a waiting request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // only one transaction in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a full store removes nothing
  a_full_none: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_FULL |-> rsp.removed_count == 7'd0)
    else $error("full status with removals");

  // not found removes nothing
  a_miss_none: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_NOT_FOUND |-> rsp.removed_count == 7'd0)
    else $error("not-found status with removals");

endmodule

bind unordered_bag_swap_remove ubsr_checker u_ubsr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
